/* rtl/core/signed_decimal_seven_segment_formatter_defines.svh */
`ifndef SIGNED_DECIMAL_SEVEN_SEGMENT_FORMATTER_DEFINES_SVH
`define SIGNED_DECIMAL_SEVEN_SEGMENT_FORMATTER_DEFINES_SVH

// check a property on the rising clock, skipped while reset is asserted
`define SDSSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property on the rising clock, also while reset is asserted
`define SDSSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/sdssf_pkg.sv */
`default_nettype none

package sdssf_pkg;

  localparam int unsigned NumDigits = 4;

  localparam logic [0:0] RegDotPosition = 1'b0;

  localparam logic [7:0] SegBlank = 8'h00;
  localparam logic [7:0] SegMinus = 8'h40;
  localparam logic [7:0] SegF     = 8'h71;
  localparam logic [7:0] SegDot   = 8'h80;

  localparam logic [15:0] PosLimit = 16'd9999;
  localparam logic [15:0] NegLimit = 16'd999;

  typedef logic [NumDigits-1:0][7:0] seg_row_t;

  typedef struct packed {
    logic     valid;
    seg_row_t seg;
  } fmt_t;

  function automatic logic [7:0] digit_seg(logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] grid_cmd(logic [1:0] pos);
    logic [7:0] g;
    unique case (pos)
      2'd0:    g = 8'h08;
      2'd1:    g = 8'h88;
      2'd2:    g = 8'h48;
      default: g = 8'hc8;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sdssf_conv.sv */
`default_nettype none

module sdssf_conv (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic signed [15:0] value_i,
  input  wire logic        [1:0]  dot_position_i,
  output sdssf_pkg::fmt_t         fmt_o
);

  function automatic logic [15:0] dabble(logic [15:0] b, logic bit_in);
    logic [15:0] t;
    t = b;
    for (int n = 0; n < 4; n++) begin
      if (t[4*n +: 4] >= 4'd5) begin
        t[4*n +: 4] = t[4*n +: 4] + 4'd3;
      end
    end
    return {t[14:0], bit_in};
  endfunction

  // stage 1: sign, magnitude, range
  logic        v1_q, neg1_q, ovp1_q, ovn1_q;
  logic [13:0] mag1_q;
  logic [1:0]  dp1_q;
  logic [15:0] raw, mag16;
  logic        neg;

  always_comb begin
    raw   = value_i;
    neg   = raw[15];
    mag16 = neg ? 16'(~raw + 16'd1) : raw;
  end

  // stage 2: upper magnitude bits into BCD
  logic        v2_q, neg2_q, ovp2_q, ovn2_q;
  logic [1:0]  dp2_q;
  logic [15:0] bcd2_q, bcd2_d;
  logic [6:0]  lo2_q;

  always_comb begin
    bcd2_d = '0;
    for (int i = 6; i >= 0; i--) begin
      bcd2_d = dabble(bcd2_d, mag1_q[7+i]);
    end
  end

  // stage 3: lower magnitude bits into BCD
  logic        v3_q, neg3_q, ovp3_q, ovn3_q;
  logic [1:0]  dp3_q;
  logic [15:0] bcd3_q, bcd3_d;

  always_comb begin
    bcd3_d = bcd2_q;
    for (int i = 6; i >= 0; i--) begin
      bcd3_d = dabble(bcd3_d, lo2_q[i]);
    end
  end

  // stage 4: blanking, sign, point and segment lookup
  logic                 v4_q;
  sdssf_pkg::seg_row_t  seg4_q, seg4_d;
  logic [3:0][3:0]      dig;
  logic [1:0]           first;
  logic [1:0]           sign_pos;
  logic [7:0]           s;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dig[k] = bcd3_q[4*(3-k) +: 4];
    end
    if (!neg3_q && (dig[0] != 4'd0 || dp3_q == 2'd3)) begin
      first = 2'd0;
    end else if (dig[0] != 4'd0 || dig[1] != 4'd0 || dp3_q == 2'd2) begin
      first = 2'd1;
    end else if (dig[0] != 4'd0 || dig[1] != 4'd0 || dig[2] != 4'd0 || dp3_q == 2'd1) begin
      first = 2'd2;
    end else begin
      first = 2'd3;
    end
    sign_pos = first - 2'd1;
    s        = '0;
    for (int k = 0; k < 4; k++) begin
      if (ovp3_q) begin
        seg4_d[k] = sdssf_pkg::SegF;
      end else if (ovn3_q) begin
        seg4_d[k] = (k == 0) ? sdssf_pkg::SegMinus : sdssf_pkg::SegF;
      end else if (2'(k) >= first) begin
        s = sdssf_pkg::digit_seg(dig[k]);
        if (dp3_q != 2'd0 && 2'(k) == 2'd3 - dp3_q) begin
          s = s | sdssf_pkg::SegDot;
        end
        seg4_d[k] = s;
      end else if (neg3_q && 2'(k) == sign_pos) begin
        seg4_d[k] = sdssf_pkg::SegMinus;
      end else begin
        seg4_d[k] = sdssf_pkg::SegBlank;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      neg1_q <= neg;
      ovp1_q <= !neg && (mag16 > sdssf_pkg::PosLimit);
      ovn1_q <= neg && (mag16 > sdssf_pkg::NegLimit);
      mag1_q <= mag16[13:0];
      dp1_q  <= dot_position_i;
    end
    if (v1_q) begin
      neg2_q <= neg1_q;
      ovp2_q <= ovp1_q;
      ovn2_q <= ovn1_q;
      dp2_q  <= dp1_q;
      bcd2_q <= bcd2_d;
      lo2_q  <= mag1_q[6:0];
    end
    if (v2_q) begin
      neg3_q <= neg2_q;
      ovp3_q <= ovp2_q;
      ovn3_q <= ovn2_q;
      dp3_q  <= dp2_q;
      bcd3_q <= bcd3_d;
    end
    if (v3_q) begin
      seg4_q <= seg4_d;
    end
  end

  assign fmt_o.valid = v4_q;
  assign fmt_o.seg   = seg4_q;

endmodule

`default_nettype wire

/* rtl/core/signed_decimal_seven_segment_formatter.sv */
// An accepted request passes the sdssf_conv stages and the strobe register,
// then digits are strobed one per cycle, thousands first, units last
// (4 strobes per request). Busy, raised after each accept, blocks start so
// the single result port sends one row at a time; outputs never stall.
// Reset (rst_ni low, asynchronous): pipeline and output empty, dot_position 0.
`default_nettype none

`include "signed_decimal_seven_segment_formatter_defines.svh"

module signed_decimal_seven_segment_formatter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic signed [15:0] value_i,
  output      logic               result_strobe_o,
  output      logic [1:0]         digit_position_o,
  output      logic [7:0]         grid_command_o,
  output      logic [7:0]         segments_o,
  output      logic               last_digit_o
);

  logic [1:0]      dot_position_q;
  logic            cfg_wr;
  logic            accept;
  logic [1:0]      gap_q;
  sdssf_pkg::fmt_t fmt;

  logic            act_q, act_d;
  logic [1:0]      pos_q, pos_d;
  logic [2:0][7:0] sh_q, sh_d;
  logic            strobe_q, strobe_d;
  logic [7:0]      seg_q, seg_d;
  logic [1:0]      opos_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == sdssf_pkg::RegDotPosition);
  assign prdata = (paddr[2] == sdssf_pkg::RegDotPosition) ? {30'd0, dot_position_q} : '0;

  assign busy   = (gap_q != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_position_q <= 2'd0;
      gap_q          <= 2'd0;
    end else begin
      if (cfg_wr) begin
        dot_position_q <= pwdata[1:0];
      end
      if (accept) begin
        gap_q <= 2'd3;
      end else if (gap_q != 2'd0) begin
        gap_q <= gap_q - 2'd1;
      end
    end
  end

  sdssf_conv u_conv (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .value_i        (value_i),
    .dot_position_i (dot_position_q),
    .fmt_o          (fmt)
  );

  // serialize four digits onto the result port
  always_comb begin
    act_d    = act_q;
    pos_d    = pos_q;
    sh_d     = sh_q;
    strobe_d = 1'b0;
    seg_d    = seg_q;
    if (fmt.valid) begin
      strobe_d = 1'b1;
      seg_d    = fmt.seg[0];
      sh_d     = fmt.seg[3:1];
      pos_d    = 2'd0;
      act_d    = 1'b1;
    end else if (act_q) begin
      strobe_d = 1'b1;
      seg_d    = sh_q[0];
      sh_d     = {8'h00, sh_q[2:1]};
      pos_d    = pos_q + 2'd1;
      act_d    = (pos_q != 2'd2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      pos_q    <= 2'd0;
      strobe_q <= 1'b0;
      opos_q   <= 2'd0;
    end else begin
      act_q    <= act_d;
      pos_q    <= pos_d;
      strobe_q <= strobe_d;
      opos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    seg_q <= seg_d;
  end

  assign result_strobe_o  = strobe_q;
  assign digit_position_o = opos_q;
  assign grid_command_o   = sdssf_pkg::grid_cmd(opos_q);
  assign segments_o       = seg_q;
  assign last_digit_o     = strobe_q && (opos_q == 2'd3);

  `SDSSF_ASSERT_ALWAYS(a_last_has_strobe, last_digit_o |-> result_strobe_o,
    "last digit flagged without a result strobe")
  `SDSSF_ASSERT(a_accept_sets_busy, accept |=> busy,
    "busy not raised after an accepted request")
  `SDSSF_ASSERT(a_digits_in_order,
    result_strobe_o && !last_digit_o |=>
      result_strobe_o && (digit_position_o == $past(digit_position_o) + 2'd1),
    "digit sequence broken before the units digit")
  `SDSSF_ASSERT(a_no_overlap, fmt.valid |-> !act_q,
    "formatted row arrived while the previous row was still being sent")

endmodule

`default_nettype wire
